// ===== rtl/core/mprq_pkg.sv =====
// Package for the multilevel priority ready queue.
// Sizing constants, port field layout and the controller command struct.
// No dependencies; every other file of the block uses it by scoped names.
package mprq_pkg;

   // Queue geometry
   localparam int LEVELS      = 16;
   localparam int LEVEL_DEPTH = 16;
   localparam int ID_WIDTH    = 8;

   localparam int LEVEL_W = $clog2(LEVELS);
   localparam int SLOT_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
   localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);

   // Transaction field widths
   localparam int PRIO_W      = 4;
   localparam int TASK_W      = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   // Request kinds carried in req_tuser
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;   // perform the accepted request
      logic load;   // capture the result into the output register
   } cmd_type;

endpackage

// ===== rtl/core/mprq_ctrl.sv =====
// Controller for the multilevel priority ready queue.
// Sequences accept, memory access and result load; drives both handshakes.
// Depends on mprq_pkg.
module mprq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output mprq_pkg::cmd_type cmd
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load;
   logic      exec;

   // Command decode
   always_comb begin
      exec = (state_ff == ST_IDLE) && req_tvalid;
      load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   end

   // Next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (exec) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd.exec   = exec;
   assign cmd.load   = load;

endmodule

// ===== rtl/core/mprq_dpath.sv =====
// Datapath for the multilevel priority ready queue.
// Holds per-level head and count registers, the entry memory and the result register.
// Depends on mprq_pkg.
module mprq_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  mprq_pkg::cmd_type                   cmd,
   input  logic                                req_mode,
   input  logic [mprq_pkg::PRIO_W-1:0]         req_prio,
   input  logic [mprq_pkg::TASK_W-1:0]         req_task,
   output logic [mprq_pkg::RSP_DATA_W-1:0]     rsp_data
);

   logic [mprq_pkg::SLOT_W-1:0]   head_ff  [mprq_pkg::LEVELS];
   logic [mprq_pkg::SLOT_W-1:0]   head_in  [mprq_pkg::LEVELS];
   logic [mprq_pkg::CNT_W-1:0]    count_ff [mprq_pkg::LEVELS];
   logic [mprq_pkg::CNT_W-1:0]    count_in [mprq_pkg::LEVELS];
   logic [mprq_pkg::ID_WIDTH-1:0] mem      [mprq_pkg::ENTRIES];

   logic [mprq_pkg::ID_WIDTH-1:0]   rd_data_ff;
   logic                            hit_ff, hit_in;
   logic                            drop_ff, drop_in;
   logic [mprq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [mprq_pkg::LEVELS-1:0]     nonempty;
   logic                            deq_found;
   logic [mprq_pkg::LEVEL_W-1:0]    deq_level;
   logic [31:0]                     prio_wide;
   logic                            in_range;
   logic [mprq_pkg::LEVEL_W-1:0]    enq_level;
   logic [mprq_pkg::LEVEL_W-1:0]    level;
   logic                            enq_ok;
   logic                            deq_ok;
   logic [mprq_pkg::CNT_W:0]        slot_sum;
   logic [mprq_pkg::SLOT_W-1:0]     tail_slot;
   logic [mprq_pkg::SLOT_W-1:0]     slot;
   logic [mprq_pkg::SLOT_W-1:0]     head_next;
   logic [mprq_pkg::ADDR_W-1:0]     addr;
   logic                            all_empty;

   // Occupancy flags and first non-empty level
   always_comb begin
      deq_found = 1'b0;
      deq_level = '0;
      for (int lv = mprq_pkg::LEVELS - 1; lv >= 0; lv--) begin
         nonempty[lv] = (count_ff[lv] != '0);
         if (nonempty[lv]) begin
            deq_found = 1'b1;
            deq_level = mprq_pkg::LEVEL_W'(lv);
         end
      end
   end

   assign all_empty = ~|nonempty;

   // Enqueue and dequeue target, slot and address selection
   always_comb begin
      prio_wide = 32'(req_prio);
      in_range  = (prio_wide < 32'(mprq_pkg::LEVELS));
      enq_level = prio_wide[mprq_pkg::LEVEL_W-1:0];
      level     = (req_mode == mprq_pkg::MODE_DEQUEUE) ? deq_level : enq_level;
      enq_ok    = (req_mode == mprq_pkg::MODE_ENQUEUE) && in_range &&
                  (count_ff[enq_level] != mprq_pkg::CNT_W'(mprq_pkg::LEVEL_DEPTH));
      deq_ok    = (req_mode == mprq_pkg::MODE_DEQUEUE) && deq_found;
      // tail = (head + count) mod depth; sum stays below twice the depth
      slot_sum  = (mprq_pkg::CNT_W+1)'(head_ff[enq_level]) +
                  (mprq_pkg::CNT_W+1)'(count_ff[enq_level]);
      if (slot_sum >= (mprq_pkg::CNT_W+1)'(mprq_pkg::LEVEL_DEPTH)) begin
         tail_slot = mprq_pkg::SLOT_W'(slot_sum -
                     (mprq_pkg::CNT_W+1)'(mprq_pkg::LEVEL_DEPTH));
      end else begin
         tail_slot = mprq_pkg::SLOT_W'(slot_sum);
      end
      slot = (req_mode == mprq_pkg::MODE_DEQUEUE) ? head_ff[deq_level] : tail_slot;
      if (head_ff[deq_level] == mprq_pkg::SLOT_W'(mprq_pkg::LEVEL_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = head_ff[deq_level] + mprq_pkg::SLOT_W'(1);
      end
      addr = mprq_pkg::ADDR_W'(level) * mprq_pkg::ADDR_W'(mprq_pkg::LEVEL_DEPTH) +
             mprq_pkg::ADDR_W'(slot);
      hit_in  = deq_ok;
      drop_in = (req_mode == mprq_pkg::MODE_ENQUEUE) && !enq_ok;
   end

   // Head and count updates
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.exec && enq_ok) begin
         count_in[enq_level] = count_ff[enq_level] + mprq_pkg::CNT_W'(1);
      end
      if (cmd.exec && deq_ok) begin
         count_in[deq_level] = count_ff[deq_level] - mprq_pkg::CNT_W'(1);
         head_in[deq_level]  = head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < mprq_pkg::LEVELS; lv++) begin
            head_ff[lv]  <= '0;
            count_ff[lv] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Entry memory: one write or one registered read per transaction
   always_ff @(posedge clock) begin
      if (cmd.exec && enq_ok) begin
         mem[addr] <= req_task[mprq_pkg::ID_WIDTH-1:0];
      end
      if (cmd.exec && deq_ok) begin
         rd_data_ff <= mem[addr];
      end
   end

   // Outcome flags captured with the access
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hit_ff  <= hit_in;
         drop_ff <= drop_in;
      end
   end

   // Result word: {pad, dropped, all_empty, out_task_id, out_valid}
   always_comb begin
      rsp_data_in                      = '0;
      rsp_data_in[0]                   = hit_ff;
      rsp_data_in[mprq_pkg::TASK_W:1]  = hit_ff ? mprq_pkg::TASK_W'(rd_data_ff) : '0;
      rsp_data_in[mprq_pkg::TASK_W+1]  = all_empty;
      rsp_data_in[mprq_pkg::TASK_W+2]  = drop_ff;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/core/multilevel_priority_ready_queue_unit.sv =====
// Multilevel strict-priority ready queue, one FIFO per level in a shared entry memory.
// A request is accepted in ST_IDLE, where the entry memory is accessed; its result then loads
// from ST_RESP once the output register is empty or being taken, and is offered on rsp_tvalid.
// The input is held from the accept until that result loads (access, then result load); a waiting
// result lets one more request in, which then holds the input until the result is taken.
// Reset (synchronous) empties every level at once; entry memory is not cleared.
module multilevel_priority_ready_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mprq_pkg::REQ_DATA_W-1:0]     req_tdata,  // [3:0] priority_req, [11:4] task_id
   input  logic                                req_tuser,  // [0] mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] out_valid, [8:1] out_task_id, [9] all_empty, [10] dropped
   output logic [mprq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   mprq_pkg::cmd_type cmd;

   mprq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mprq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_mode (req_tuser),
      .req_prio (req_tdata[mprq_pkg::PRIO_W-1:0]),
      .req_task (req_tdata[mprq_pkg::PRIO_W+mprq_pkg::TASK_W-1:mprq_pkg::PRIO_W]),
      .rsp_data (rsp_tdata)
   );

endmodule

// ===== rtl/core/mprq_checker.sv =====
// Port-level checker for the multilevel priority ready queue.
// Bound to multilevel_priority_ready_queue_unit; depends on mprq_pkg.
module mprq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mprq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One request in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // A dropped enqueue never returns an identifier
   a_drop_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[mprq_pkg::TASK_W+2]))
      else $error("dropped and out_valid both set");

   // No identifier means a zero identifier field
   a_miss_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[mprq_pkg::TASK_W:1] == '0)
      else $error("identifier nonzero without out_valid");

endmodule

bind multilevel_priority_ready_queue_unit mprq_checker u_mprq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
